// ----- hdl/generalized_box_iou_unit_defines.svh -----
// assertion macros shared by the generalized box iou checker
`ifndef GENERALIZED_BOX_IOU_UNIT_DEFINES_SVH
`define GENERALIZED_BOX_IOU_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define GBIOU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbiou check failed");

// next-cycle implication, sampled on clk, off during reset
`define GBIOU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbiou check failed");

`endif

// ----- hdl/gbiou_pkg.sv -----
// types and constants shared by the generalized box iou unit
package gbiou_pkg;

  localparam int COORD_W       = 16;
  localparam int NUM_COORDS    = 8;
  localparam int IN_DATA_W     = ((COORD_W * NUM_COORDS + 7) / 8) * 8;
  localparam int AREA_W        = 2 * COORD_W;
  localparam int PROD_W        = 2 * AREA_W;
  localparam int OVR_W         = 16;
  localparam int GEN_W         = 17;
  localparam int UNI_W         = AREA_W;
  localparam int STAT_W        = 2;
  localparam int OUT_FIELDS_W  = OVR_W + GEN_W + UNI_W;
  localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int FRAC_BITS_DEF = 15;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_MALFORMED = 2'd1,
    STAT_ZERO_AREA = 2'd2
  } status_t;

  typedef struct packed {
    status_t             status;
    logic                neg;
    logic [AREA_W-1:0]   uni;
    logic [AREA_W-1:0]   iou_rem;
    logic [PROD_W-1:0]   g_den;
    logic [PROD_W-1:0]   g_rem;
  } div_t;

endpackage

// ----- hdl/gbiou_cell.sv -----
// one restoring division cell: one quotient bit for iou and for giou per request
module gbiou_cell #(
  parameter int QW       = gbiou_pkg::FRAC_BITS_DEF + 1,
  parameter bit DO_SHIFT = 1'b1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  gbiou_pkg::div_t  in_d,
  input  logic [QW-1:0]    in_iq,
  input  logic [QW-1:0]    in_gq,
  output logic             out_vld,
  output gbiou_pkg::div_t  out_d,
  output logic [QW-1:0]    out_iq,
  output logic [QW-1:0]    out_gq
);

  logic [gbiou_pkg::AREA_W:0] irem_s, irem_d;
  logic [gbiou_pkg::PROD_W:0] grem_s, grem_d;
  logic                       ige, gge;
  gbiou_pkg::div_t            d_nxt, d_r;
  logic [QW-1:0]              iq_nxt, gq_nxt, iq_r, gq_r;
  logic                       vld_r;

  always_comb begin
    irem_s = DO_SHIFT ? {in_d.iou_rem, 1'b0} : {1'b0, in_d.iou_rem};
    irem_d = irem_s - {1'b0, in_d.uni};
    ige    = irem_s >= {1'b0, in_d.uni};
    grem_s = DO_SHIFT ? {in_d.g_rem, 1'b0} : {1'b0, in_d.g_rem};
    grem_d = grem_s - {1'b0, in_d.g_den};
    gge    = grem_s >= {1'b0, in_d.g_den};
    d_nxt         = in_d;
    d_nxt.iou_rem = ige ? irem_d[gbiou_pkg::AREA_W-1:0] : irem_s[gbiou_pkg::AREA_W-1:0];
    d_nxt.g_rem   = gge ? grem_d[gbiou_pkg::PROD_W-1:0] : grem_s[gbiou_pkg::PROD_W-1:0];
    iq_nxt = {in_iq[QW-2:0], ige};
    gq_nxt = {in_gq[QW-2:0], gge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r  <= d_nxt;
      iq_r <= iq_nxt;
      gq_r <= gq_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;
  assign out_iq  = iq_r;
  assign out_gq  = gq_r;

endmodule

// ----- hdl/gbiou_front.sv -----
// front pipeline: box extents, areas, union, cross products and giou numerator
module gbiou_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_vld,
  input  logic [gbiou_pkg::IN_DATA_W-1:0]  in_data,
  output logic                             out_vld,
  output gbiou_pkg::div_t                  out_d
);

  localparam int CW = gbiou_pkg::COORD_W;
  localparam int AW = gbiou_pkg::AREA_W;
  localparam int PW = gbiou_pkg::PROD_W;

  logic [CW-1:0] l1, t1, r1, b1, l2, t2, r2, b2;
  logic [CW-1:0] lx, rx, ty, by, ex_l, ex_r, ey_t, ey_b;
  logic          mal;

  // stage 1: extents
  logic          s1_vld_r, s1_mal_r;
  logic [CW-1:0] s1_w1_r, s1_h1_r, s1_w2_r, s1_h2_r;
  logic [CW-1:0] s1_iw_r, s1_ih_r, s1_ew_r, s1_eh_r;
  // stage 2: areas
  logic          s2_vld_r, s2_mal_r;
  logic [AW-1:0] s2_a1_r, s2_a2_r, s2_inter_r, s2_encl_r;
  // stage 3: union
  logic              s3_vld_r;
  gbiou_pkg::status_t s3_stat_r, s3_stat_nxt;
  logic [AW-1:0]     s3_uni_r, s3_inter_r, s3_encl_r, s3_gap_r;
  logic [AW:0]       uni_sum;
  logic [AW-1:0]     uni_nxt;
  // stage 4: cross products
  logic              s4_vld_r;
  gbiou_pkg::status_t s4_stat_r;
  logic [AW-1:0]     s4_uni_r, s4_inter_r;
  logic [PW-1:0]     s4_pos_r, s4_negp_r, s4_den_r;
  // stage 5: signed numerator magnitude
  logic              s5_vld_r;
  gbiou_pkg::div_t   s5_d_r;
  logic              pos_ge;

  always_comb begin
    l1 = in_data[0*CW +: CW];
    t1 = in_data[1*CW +: CW];
    r1 = in_data[2*CW +: CW];
    b1 = in_data[3*CW +: CW];
    l2 = in_data[4*CW +: CW];
    t2 = in_data[5*CW +: CW];
    r2 = in_data[6*CW +: CW];
    b2 = in_data[7*CW +: CW];
    mal  = (r1 < l1) || (b1 < t1) || (r2 < l2) || (b2 < t2);
    lx   = (l1 > l2) ? l1 : l2;
    rx   = (r1 < r2) ? r1 : r2;
    ty   = (t1 > t2) ? t1 : t2;
    by   = (b1 < b2) ? b1 : b2;
    ex_l = (l1 < l2) ? l1 : l2;
    ex_r = (r1 > r2) ? r1 : r2;
    ey_t = (t1 < t2) ? t1 : t2;
    ey_b = (b1 > b2) ? b1 : b2;
  end

  always_comb begin
    uni_sum = {1'b0, s2_a1_r} + {1'b0, s2_a2_r} - {1'b0, s2_inter_r};
    uni_nxt = uni_sum[AW-1:0];
    if (s2_mal_r) begin
      s3_stat_nxt = gbiou_pkg::STAT_MALFORMED;
    end else if ((uni_nxt == '0) || (s2_encl_r == '0)) begin
      s3_stat_nxt = gbiou_pkg::STAT_ZERO_AREA;
    end else begin
      s3_stat_nxt = gbiou_pkg::STAT_OK;
    end
  end

  assign pos_ge = s4_pos_r >= s4_negp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mal_r <= mal;
      s1_w1_r  <= r1 - l1;
      s1_h1_r  <= b1 - t1;
      s1_w2_r  <= r2 - l2;
      s1_h2_r  <= b2 - t2;
      s1_iw_r  <= (rx > lx) ? (rx - lx) : '0;
      s1_ih_r  <= (by > ty) ? (by - ty) : '0;
      s1_ew_r  <= ex_r - ex_l;
      s1_eh_r  <= ey_b - ey_t;

      s2_mal_r   <= s1_mal_r;
      s2_a1_r    <= AW'(s1_w1_r) * AW'(s1_h1_r);
      s2_a2_r    <= AW'(s1_w2_r) * AW'(s1_h2_r);
      s2_inter_r <= AW'(s1_iw_r) * AW'(s1_ih_r);
      s2_encl_r  <= AW'(s1_ew_r) * AW'(s1_eh_r);

      s3_stat_r  <= s3_stat_nxt;
      s3_uni_r   <= uni_nxt;
      s3_inter_r <= s2_inter_r;
      s3_encl_r  <= s2_encl_r;
      s3_gap_r   <= s2_encl_r - uni_nxt;

      s4_stat_r  <= s3_stat_r;
      s4_uni_r   <= s3_uni_r;
      s4_inter_r <= s3_inter_r;
      s4_pos_r   <= PW'(s3_inter_r) * PW'(s3_encl_r);
      s4_negp_r  <= PW'(s3_gap_r) * PW'(s3_uni_r);
      s4_den_r   <= PW'(s3_uni_r) * PW'(s3_encl_r);

      s5_d_r.status  <= s4_stat_r;
      s5_d_r.neg     <= !pos_ge;
      s5_d_r.uni     <= s4_uni_r;
      s5_d_r.iou_rem <= s4_inter_r;
      s5_d_r.g_den   <= s4_den_r;
      s5_d_r.g_rem   <= pos_ge ? (s4_pos_r - s4_negp_r) : (s4_negp_r - s4_pos_r);
    end
  end

  assign out_vld = s5_vld_r;
  assign out_d   = s5_d_r;

endmodule

// ----- hdl/generalized_box_iou_unit.sv -----
// generalized box iou unit: front pipeline, chain of division cells, output skid
//
//  channel | dir | fields (lowest bit first)
//  in_     | in  | tdata: first l,t,r,b then second l,t,r,b, 16 bits each
//  out_    | out | tdata: overlap_ratio, general_ratio, union_area; tuser: status
//
//  one pair accepted per cycle while in_tready is high
//  five front stages, FRAC_BITS + 1 division cells, one output register
//  reset clears every valid flag, payload registers are not reset
//  a result stalled at the output parks in a one-entry skid stage
//  in_tready drops only while that skid stage is full
module generalized_box_iou_unit #(
  parameter int FRAC_BITS = gbiou_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // first_left, first_top, first_right, first_bottom,
  // second_left, second_top, second_right, second_bottom
  input  logic [gbiou_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // overlap_ratio, general_ratio, union_area, zero fill
  output logic [gbiou_pkg::OUT_DATA_W-1:0]  out_tdata,
  // status
  output logic [gbiou_pkg::STAT_W-1:0]      out_tuser
);

  localparam int QW    = FRAC_BITS + 1;
  localparam int NCELL = FRAC_BITS + 1;

  typedef struct packed {
    gbiou_pkg::status_t                  status;
    logic [gbiou_pkg::UNI_W-1:0]         uni;
    logic [gbiou_pkg::GEN_W-1:0]         gen;
    logic [gbiou_pkg::OVR_W-1:0]         ovr;
  } res_t;

  logic            en;
  logic            c_vld [0:NCELL];
  gbiou_pkg::div_t c_d   [0:NCELL];
  logic [QW-1:0]   c_iq  [0:NCELL];
  logic [QW-1:0]   c_gq  [0:NCELL];

  res_t                        res;
  logic [gbiou_pkg::GEN_W-1:0] gen_mag;
  logic                        out_vld_r, out_vld_nxt, skid_vld_r, skid_vld_nxt;
  res_t                        out_res_r, out_res_nxt, skid_res_r, skid_res_nxt;

  assign en        = !skid_vld_r;
  assign in_tready = en;

  gbiou_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_tvalid),
    .in_data (in_tdata),
    .out_vld (c_vld[0]),
    .out_d   (c_d[0])
  );

  assign c_iq[0] = '0;
  assign c_gq[0] = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    gbiou_cell #(
      .QW       (QW),
      .DO_SHIFT (i != 0)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (c_vld[i]),
      .in_d    (c_d[i]),
      .in_iq   (c_iq[i]),
      .in_gq   (c_gq[i]),
      .out_vld (c_vld[i+1]),
      .out_d   (c_d[i+1]),
      .out_iq  (c_iq[i+1]),
      .out_gq  (c_gq[i+1])
    );
  end

  always_comb begin
    gen_mag    = gbiou_pkg::GEN_W'(c_gq[NCELL]);
    res.status = c_d[NCELL].status;
    case (c_d[NCELL].status)
      gbiou_pkg::STAT_OK: begin
        res.uni = c_d[NCELL].uni;
        res.ovr = gbiou_pkg::OVR_W'(c_iq[NCELL]);
        res.gen = c_d[NCELL].neg ? ((~gen_mag) + gbiou_pkg::GEN_W'(1)) : gen_mag;
      end
      gbiou_pkg::STAT_ZERO_AREA: begin
        res.uni = c_d[NCELL].uni;
        res.ovr = '0;
        res.gen = '0;
      end
      default: begin
        res.uni = '0;
        res.ovr = '0;
        res.gen = '0;
      end
    endcase
  end

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_res_nxt  = out_res_r;
    skid_vld_nxt = skid_vld_r;
    skid_res_nxt = skid_res_r;
    if (!out_vld_r || out_tready) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_res_nxt  = skid_res_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = c_vld[NCELL];
        out_res_nxt = res;
      end
    end else if (c_vld[NCELL] && !skid_vld_r) begin
      skid_vld_nxt = 1'b1;
      skid_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(gbiou_pkg::OUT_DATA_W - gbiou_pkg::OUT_FIELDS_W)'(0),
                       out_res_r.uni, out_res_r.gen, out_res_r.ovr};
  assign out_tuser  = out_res_r.status;

endmodule

// ----- hdl/gbiou_checker.sv -----
// port-level checks for the generalized box iou unit, bound to the top level
`include "generalized_box_iou_unit_defines.svh"

module gbiou_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [gbiou_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [gbiou_pkg::STAT_W-1:0]      out_tuser
);

  localparam int UNI_LO = gbiou_pkg::OVR_W + gbiou_pkg::GEN_W;
  localparam int UNI_HI = UNI_LO + gbiou_pkg::UNI_W - 1;

  // stalled result holds
  `GBIOU_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // any non-ok status carries all-zero fields
  `GBIOU_ASSERT_IMP(a_bad_status_zero, out_tvalid && (out_tuser != gbiou_pkg::STAT_OK), out_tdata == '0)

  // ok status implies a nonzero union
  `GBIOU_ASSERT_IMP(a_ok_union, out_tvalid && (out_tuser == gbiou_pkg::STAT_OK), out_tdata[UNI_HI:UNI_LO] != '0)

  // input back-pressure only while a result is waiting
  `GBIOU_ASSERT_IMP(a_stall_has_result, !in_tready, out_tvalid)

endmodule

bind generalized_box_iou_unit gbiou_checker u_gbiou_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the generalized box iou unit: directed and random box pairs
`timescale 1ns / 1ps

module testbench;
  import gbiou_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int DRAIN_CYCLES = FRAC_BITS_DEF + 7 + 20;
  localparam int MAX_COORD = (1 << COORD_W) - 1;

  typedef struct {
    logic [OVR_W-1:0] overlap;
    logic [GEN_W-1:0] general;
    logic [UNI_W-1:0] union_px;
    status_t          status;
  } score_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]     out_tuser;

  score_t pending_scores[$];
  int     errors = 0;
  bit     send_steady = 1'b0;
  bit     sink_steady = 1'b0;

  generalized_box_iou_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic score_t score_pair(input logic [IN_DATA_W-1:0] pair);
    logic [63:0] l1, t1, r1, b1, l2, t2, r2, b2;
    logic [63:0] area_a, area_b, lo_x, hi_x, lo_y, hi_y, iw, ih, ovl, uni, ew, eh, encl;
    logic [127:0] gain, loss, mag, den, q;
    score_t s;
    l1 = 64'(pair[15:0]);    t1 = 64'(pair[31:16]);
    r1 = 64'(pair[47:32]);   b1 = 64'(pair[63:48]);
    l2 = 64'(pair[79:64]);   t2 = 64'(pair[95:80]);
    r2 = 64'(pair[111:96]);  b2 = 64'(pair[127:112]);
    s.overlap = '0;
    s.general = '0;
    s.union_px = '0;
    s.status = STAT_OK;
    if (r1 < l1 || b1 < t1 || r2 < l2 || b2 < t2) begin
      s.status = STAT_MALFORMED;
      return s;
    end
    area_a = (r1 - l1) * (b1 - t1);
    area_b = (r2 - l2) * (b2 - t2);
    lo_x = (l1 > l2) ? l1 : l2;
    hi_x = (r1 < r2) ? r1 : r2;
    lo_y = (t1 > t2) ? t1 : t2;
    hi_y = (b1 < b2) ? b1 : b2;
    iw = (hi_x > lo_x) ? hi_x - lo_x : 64'd0;
    ih = (hi_y > lo_y) ? hi_y - lo_y : 64'd0;
    ovl = iw * ih;
    uni = area_a + area_b - ovl;
    ew = ((r1 > r2) ? r1 : r2) - ((l1 < l2) ? l1 : l2);
    eh = ((b1 > b2) ? b1 : b2) - ((t1 < t2) ? t1 : t2);
    encl = ew * eh;
    s.union_px = uni[UNI_W-1:0];
    if (uni == 0 || encl == 0) begin
      s.status = STAT_ZERO_AREA;
      return s;
    end
    q = ({64'd0, ovl} << FRAC) / {64'd0, uni};
    s.overlap = q[OVR_W-1:0];
    // giou = (ovl*encl - (encl-uni)*uni) / (uni*encl)
    gain = {64'd0, ovl} * {64'd0, encl};
    loss = {64'd0, encl - uni} * {64'd0, uni};
    den = {64'd0, uni} * {64'd0, encl};
    mag = (gain >= loss) ? gain - loss : loss - gain;
    q = (mag << FRAC) / den;
    if (gain < loss) begin
      q = -q;
    end
    s.general = q[GEN_W-1:0];
    return s;
  endfunction

  function automatic int pick_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] clamp_coord(input int v);
    if (v < 0) begin
      return 16'd0;
    end else if (v > MAX_COORD) begin
      return 16'hffff;
    end
    return v[15:0];
  endfunction

  function automatic logic [63:0] box(input int l, input int t, input int r, input int b);
    return {clamp_coord(b), clamp_coord(r), clamp_coord(t), clamp_coord(l)};
  endfunction

  function automatic logic [63:0] rand_box();
    int l, t, span, sel;
    sel = $urandom_range(0, 99);
    span = (sel < 70) ? 255 : (sel < 90) ? 4095 : MAX_COORD;
    l = $urandom_range(0, MAX_COORD);
    t = $urandom_range(0, MAX_COORD);
    return box(l, t, l + int'($urandom_range(0, span)), t + int'($urandom_range(0, span)));
  endfunction

  function automatic logic [63:0] near_box(input logic [63:0] base);
    int l, t, w, h, nl, nt;
    l = int'(base[15:0]);
    t = int'(base[31:16]);
    w = int'(base[47:32]) - l;
    h = int'(base[63:48]) - t;
    nl = l + int'($urandom_range(0, 2 * w + 2)) - (w + 1);
    nt = t + int'($urandom_range(0, 2 * h + 2)) - (h + 1);
    nl = int'(clamp_coord(nl));
    nt = int'(clamp_coord(nt));
    return box(nl, nt, nl + int'($urandom_range(0, 2 * w + 1)),
               nt + int'($urandom_range(0, 2 * h + 1)));
  endfunction

  // one request on the input channel, expectation queued on acceptance
  task automatic send_pair(input logic [63:0] first_box, input logic [63:0] second_box);
    int gap;
    gap = pick_gap(send_steady);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {second_box, first_box};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_scores.push_back(score_pair({second_box, first_box}));
  endtask

  initial begin
    forever begin
      int run, stall;
      run = $urandom_range(1, 40);
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap(sink_steady);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected 'h%0h actual 'h%0h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    score_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_scores.size() == 0) begin
        $display("%0t unexpected result: expected none actual 'h%0h / %0d",
                 $time, out_tdata, out_tuser);
        errors++;
      end else begin
        want = pending_scores.pop_front();
        check_field("overlap_ratio", 64'(want.overlap), 64'(out_tdata[OVR_W-1:0]));
        check_field("general_ratio", 64'(want.general),
                    64'(out_tdata[OVR_W+GEN_W-1:OVR_W]));
        check_field("union_area", 64'(want.union_px),
                    64'(out_tdata[OVR_W+GEN_W+UNI_W-1:OVR_W+GEN_W]));
        check_field("status", 64'(want.status), 64'(out_tuser));
      end
    end
  end

  task automatic test_extreme_boxes();
    send_pair(box(0, 0, MAX_COORD, MAX_COORD), box(0, 0, MAX_COORD, MAX_COORD));
    send_pair(box(0, 0, MAX_COORD, MAX_COORD), box(65534, 65534, MAX_COORD, MAX_COORD));
    send_pair(box(0, 0, 1, 1), box(65534, 65534, MAX_COORD, MAX_COORD));
    send_pair(box(100, 100, 300, 300), box(150, 120, 200, 250));
    send_pair(box(10, 10, 20, 20), box(20, 10, 30, 20));
    send_pair(box(0, 0, 10, 10), box(5, 5, 15, 15));
    send_pair(box(0, 0, 100, 50), box(50, 50, 150, 100));
    send_pair(box(5, 5, 5, 50), box(0, 0, 10, 10));
  endtask

  task automatic test_malformed_boxes();
    send_pair(box(20, 0, 10, 10), box(0, 0, 10, 10));
    send_pair(box(0, 20, 10, 10), box(0, 0, 10, 10));
    send_pair(box(0, 0, 10, 10), box(11, 0, 10, 10));
    send_pair(box(0, 0, 10, 10), box(0, 11, 10, 10));
    send_pair(box(MAX_COORD, 0, 0, MAX_COORD), box(0, MAX_COORD, MAX_COORD, 0));
  endtask

  task automatic test_zero_area_boxes();
    send_pair(box(0, 0, 0, 0), box(0, 0, 0, 0));
    send_pair(box(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD),
              box(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD));
    send_pair(box(3, 0, 3, 9), box(7, 2, 7, 5));
    send_pair(box(0, 4, 9, 4), box(2, 8, 6, 8));
    send_pair(box(1, 1, 1, 1), box(40000, 3, 40000, 3));
  endtask

  task automatic test_random_pairs();
    logic [63:0] a, b;
    int sel;
    for (int k = 0; k < 1100; k++) begin
      if (k % 100 == 0) begin
        send_steady = ($urandom_range(0, 3) == 0);
        sink_steady = ($urandom_range(0, 3) == 0);
      end
      a = rand_box();
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        b = a;
      end else if (sel < 65) begin
        b = near_box(a);
      end else begin
        b = rand_box();
      end
      if ($urandom_range(0, 1)) begin
        send_pair(a, b);
      end else begin
        send_pair(b, a);
      end
    end
  endtask

  task automatic test_random_noise();
    logic [63:0] a, b;
    for (int k = 0; k < 300; k++) begin
      if (k % 100 == 0) begin
        send_steady = ($urandom_range(0, 2) == 0);
        sink_steady = ($urandom_range(0, 2) == 0);
      end
      if ($urandom_range(0, 1)) begin
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
      end else begin
        // well-formed pair with one edge pair swapped
        a = rand_box();
        b = near_box(a);
        case ($urandom_range(0, 3))
          0: a = {a[63:48], a[15:0], a[31:16], a[47:32]};
          1: a = {a[31:16], a[47:32], a[63:48], a[15:0]};
          2: b = {b[63:48], b[15:0], b[31:16], b[47:32]};
          default: b = {b[31:16], b[47:32], b[63:48], b[15:0]};
        endcase
      end
      send_pair(a, b);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extreme_boxes();
    test_malformed_boxes();
    test_zero_area_boxes();
    test_random_pairs();
    test_random_noise();
    in_tvalid <= 1'b0;
    sink_steady = 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
